// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the history compressor.
// Defining NO_ASSERTIONS compiles every use down to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked property, disabled while reset is asserted
`define SHC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");
// Condition that must never be seen at a clock edge
`define SHC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define SHC_ASSERT(lbl, clk, rst_n, prop)
`define SHC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== sv/shc_pkg.sv =====
// Types, codes and constants of the sensor history compressor.
// No dependencies; used by the top level.
package shc_pkg;

    // One history record as held in the ring memory
    typedef struct packed {
        logic [7:0]         source;
        logic signed [15:0] temp;
        logic signed [15:0] vcc;
        logic [7:0]         minutes;
    } record_t;

    localparam int RECORD_W = $bits(record_t);

    // Request operation codes
    localparam logic [1:0] OP_SAMPLE     = 2'd0;
    localparam logic [1:0] OP_STORE      = 2'd1;
    localparam logic [1:0] OP_ITER_START = 2'd2;
    localparam logic [1:0] OP_ITER_PREV  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACC  = 2'd0;
    localparam logic [1:0] CFG_TDIV = 2'd1;
    localparam logic [1:0] CFG_VDIV = 2'd2;

    // Merge thresholds and spans in minutes
    localparam logic [15:0] HOUR_TRIGGER       = 16'd120;
    localparam logic [15:0] THREE_HOUR_TRIGGER = 16'd1620;
    localparam logic [15:0] HOUR_SPAN          = 16'd60;
    localparam logic [15:0] THREE_HOUR_SPAN    = 16'd180;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SAMPLE_CHK,
        S_DIV_WAIT,
        S_STORE_WR,
        S_ADD3,
        S_POST,
        S_M_START,
        S_M_ACC,
        S_M_DIV,
        S_M_WR,
        S_M_CP,
        S_M_DONE,
        S_DIFF_RD,
        S_DIFF_MUL,
        S_DIFF_SUB,
        S_IT_DATA,
        S_FINISH
    } state_t;

    // Which division is in flight
    typedef enum logic [2:0] {
        DK_AVG_T,
        DK_AVG_V,
        DK_SCL_T,
        DK_SCL_V,
        DK_MRG_T,
        DK_MRG_V
    } div_kind_t;

    // A zero divisor acts as one
    function automatic logic [7:0] div_or_one(input logic [7:0] d);
        return (d == 8'd0) ? 8'd1 : d;
    endfunction

endpackage

// ===== sv/shc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module shc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/shc_div.sv =====
// Radix-2 restoring divider: signed 32-bit dividend by unsigned 16-bit divisor,
// quotient truncated toward zero, one bit per cycle. No dependencies.
module shc_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic [15:0]        divisor,
    output logic               done,
    output logic signed [31:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  step_reg, step_next;
    logic        neg_reg, neg_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [16:0] rem_sh;
    logic [16:0] rem_sub;

    // One restoring step
    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[31]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            neg_next  = dividend[31];
            quo_next  = dividend[31] ? 32'(-dividend) : 32'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sub[15:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[15:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== sv/sensor_history_compressor.sv =====
// Sensor history compressor: sequencer around the history ring memory.
// Depends on shc_pkg, shc_ram, shc_div and assert_macros.svh.
//
// Usage:
// - Input channel in_valid/in_stall carries one request (op and fields);
//   output channel out_valid/out_stall returns exactly one result for it.
// - One request is handled at a time; in_stall is high from acceptance until
//   the result is loaded into the output register.
// - Each stored record runs four divisions through the shared serial divider
//   (two for a direct store).
// - A merge reads each record it walks from the ring memory and runs two
//   divisions; a store may trigger two merges. The divider and the single
//   read port of the ring memory set the pace of this work.
// - The output register holds a finished result while out_stall is high; the
//   next request may be accepted meanwhile, and its result waits in the
//   sequencer until the output register is free.
// - Reset empties the history (no clearing pass is needed), loads the
//   configuration defaults and drops out_valid.
// - Configuration is written through cfg_we/cfg_index/cfg_data; the user
//   must do so only while idle, as the block itself does not enforce it.
`include "assert_macros.svh"

module sensor_history_compressor
    import shc_pkg::*;
#(
    parameter int HIST_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [7:0]         minute_now,
    input  logic signed [15:0] temp,
    input  logic signed [15:0] vcc,
    input  logic [7:0]         record_source,
    input  logic [7:0]         record_minutes,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic               stored,
    output logic signed [15:0] diff,
    output logic               entry_valid,
    output logic [7:0]         entry_source,
    output logic signed [15:0] entry_temp,
    output logic signed [15:0] entry_vcc,
    output logic [7:0]         entry_minutes,
    output logic [15:0]        minutes_before
);

    localparam int IDX_W = $clog2(HIST_DEPTH);
    localparam int CNT_W = $clog2(HIST_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HIST_DEPTH - 1);

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : IDX_W'(i + 1'b1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : IDX_W'(i - 1'b1);
    endfunction

    state_t    state_reg, state_next;
    div_kind_t kind_reg, kind_next;

    // captured request
    logic [1:0]         op_reg;
    logic [7:0]         now_reg;
    logic signed [15:0] tin_reg;
    logic signed [15:0] vin_reg;
    logic [7:0]         rsrc_reg;
    logic [7:0]         rmin_reg;

    // configuration
    logic [7:0] acc_reg, tdiv_reg, vdiv_reg;

    // block state
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [31:0]      tsum_reg, tsum_next;
    logic [31:0]      vsum_reg, vsum_next;
    logic [15:0]      scount_reg, scount_next;
    logic [7:0]       last_min_reg, last_min_next;
    logic [15:0]      msh_reg, msh_next;
    logic [15:0]      ms3_reg, ms3_next;
    logic [IDX_W-1:0] hidx_reg, hidx_next;
    logic [IDX_W-1:0] h3idx_reg, h3idx_next;
    logic [IDX_W-1:0] it_idx_reg, it_idx_next;
    logic [15:0]      it_min_reg, it_min_next;

    // record being stored
    logic [7:0]         rec_src_reg, rec_src_next;
    logic signed [15:0] rec_t_reg, rec_t_next;
    logic signed [15:0] rec_v_reg, rec_v_next;
    logic [7:0]         rec_min_reg, rec_min_next;

    // merge walk
    logic             m_three_reg, m_three_next;
    logic [IDX_W-1:0] m_src_reg, m_src_next;
    logic [IDX_W-1:0] m_dst_reg, m_dst_next;
    logic [15:0]      m_mins_reg, m_mins_next;
    logic [31:0]      m_at_reg, m_at_next;
    logic [31:0]      m_av_reg, m_av_next;
    logic [CNT_W-1:0] m_cnt_reg, m_cnt_next;
    logic [7:0]       m_source_reg, m_source_next;

    logic [15:0] prod_reg, prod_next;

    // pending result
    logic               res_stored_reg, res_stored_next;
    logic [15:0]        res_diff_reg, res_diff_next;
    logic               res_ev_reg, res_ev_next;
    logic [7:0]         res_src_reg, res_src_next;
    logic [15:0]        res_t_reg, res_t_next;
    logic [15:0]        res_v_reg, res_v_next;
    logic [7:0]         res_min_reg, res_min_next;
    logic [15:0]        res_mb_reg, res_mb_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               o_stored_reg;
    logic [15:0]        o_diff_reg;
    logic               o_ev_reg;
    logic [7:0]         o_src_reg;
    logic [15:0]        o_t_reg;
    logic [15:0]        o_v_reg;
    logic [7:0]         o_min_reg;
    logic [15:0]        o_mb_reg;

    logic in_accept;
    logic load_out;

    // memory and divider hookup
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    record_t             ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [RECORD_W-1:0] ram_rdata_raw;
    record_t             ram_rdata;

    logic               div_start;
    logic signed [31:0] div_dividend;
    logic [15:0]        div_divisor;
    logic               div_done;
    logic signed [31:0] div_quot;

    // scratch values
    logic [7:0]         elapsed;
    logic [7:0]         tdiv_eff;
    logic [7:0]         vdiv_eff;
    logic [15:0]        sum16;
    logic [15:0]        limit;
    logic [IDX_W-1:0]   idx_tmp;
    logic signed [24:0] prod_full;

    assign ram_rdata = ram_rdata_raw;
    assign elapsed   = now_reg - last_min_reg;
    assign tdiv_eff  = div_or_one(tdiv_reg);
    assign vdiv_eff  = div_or_one(vdiv_reg);
    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign prod_full = ram_rdata.temp * $signed({1'b0, tdiv_eff});

    shc_ram #(
        .WIDTH (RECORD_W),
        .DEPTH (HIST_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    shc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Sequencer: next state, datapath updates, memory and divider control
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        tsum_next     = tsum_reg;
        vsum_next     = vsum_reg;
        scount_next   = scount_reg;
        last_min_next = last_min_reg;
        msh_next      = msh_reg;
        ms3_next      = ms3_reg;
        hidx_next     = hidx_reg;
        h3idx_next    = h3idx_reg;
        it_idx_next   = it_idx_reg;
        it_min_next   = it_min_reg;
        rec_src_next  = rec_src_reg;
        rec_t_next    = rec_t_reg;
        rec_v_next    = rec_v_reg;
        rec_min_next  = rec_min_reg;
        m_three_next  = m_three_reg;
        m_src_next    = m_src_reg;
        m_dst_next    = m_dst_reg;
        m_mins_next   = m_mins_reg;
        m_at_next     = m_at_reg;
        m_av_next     = m_av_reg;
        m_cnt_next    = m_cnt_reg;
        m_source_next = m_source_reg;
        prod_next     = prod_reg;
        res_stored_next = res_stored_reg;
        res_diff_next   = res_diff_reg;
        res_ev_next     = res_ev_reg;
        res_src_next    = res_src_reg;
        res_t_next      = res_t_reg;
        res_v_next      = res_v_reg;
        res_min_next    = res_min_reg;
        res_mb_next     = res_mb_reg;
        load_out     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = m_dst_reg;
        ram_wdata    = ram_rdata;
        ram_re       = 1'b0;
        ram_raddr    = m_src_reg;
        div_start    = 1'b0;
        div_dividend = $signed(tsum_reg);
        div_divisor  = scount_reg;
        sum16        = '0;
        limit        = HOUR_SPAN;
        idx_tmp      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_stored_next = 1'b0;
                    res_diff_next   = '0;
                    res_ev_next     = 1'b0;
                    res_src_next    = '0;
                    res_t_next      = '0;
                    res_v_next      = '0;
                    res_min_next    = '0;
                    res_mb_next     = '0;
                    state_next      = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (op_reg)
                    OP_SAMPLE:
                    begin
                        if (scount_reg != 16'hFFFF)
                        begin
                            scount_next = scount_reg + 16'd1;
                        end
                        tsum_next  = tsum_reg + {{16{tin_reg[15]}}, tin_reg};
                        vsum_next  = vsum_reg + {{16{vin_reg[15]}}, vin_reg};
                        state_next = S_SAMPLE_CHK;
                    end
                    OP_STORE:
                    begin
                        rec_src_next = rsrc_reg;
                        rec_t_next   = tin_reg;
                        rec_v_next   = vin_reg;
                        rec_min_next = rmin_reg;
                        div_start    = 1'b1;
                        div_dividend = 32'(tin_reg);
                        div_divisor  = {8'd0, tdiv_eff};
                        kind_next    = DK_SCL_T;
                        state_next   = S_DIV_WAIT;
                    end
                    OP_ITER_START:
                    begin
                        it_idx_next = head_reg;
                        it_min_next = {8'd0, elapsed};
                        res_mb_next = {8'd0, elapsed};
                        state_next  = S_FINISH;
                    end
                    OP_ITER_PREV:
                    begin
                        idx_tmp     = idx_prev(it_idx_reg);
                        it_idx_next = idx_tmp;
                        if (idx_tmp != tail_reg)
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = idx_tmp;
                            state_next = S_IT_DATA;
                        end
                        else
                        begin
                            res_mb_next = it_min_reg;
                            state_next  = S_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // Store an average once enough minutes have passed
            S_SAMPLE_CHK:
            begin
                if (elapsed >= acc_reg)
                begin
                    rec_src_next = 8'd1;
                    rec_min_next = elapsed;
                    div_start    = 1'b1;
                    div_dividend = $signed(tsum_reg);
                    div_divisor  = scount_reg;
                    kind_next    = DK_AVG_T;
                    state_next   = S_DIV_WAIT;
                end
                else
                begin
                    state_next = S_DIFF_RD;
                end
            end

            // Collect a quotient and chain the next division, or move on after the last
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    case (kind_reg)
                        DK_AVG_T:
                        begin
                            rec_t_next   = div_quot[15:0];
                            div_start    = 1'b1;
                            div_dividend = $signed(vsum_reg);
                            div_divisor  = scount_reg;
                            kind_next    = DK_AVG_V;
                        end
                        DK_AVG_V:
                        begin
                            rec_v_next      = div_quot[15:0];
                            last_min_next   = now_reg;
                            tsum_next       = '0;
                            vsum_next       = '0;
                            scount_next     = '0;
                            res_stored_next = 1'b1;
                            div_start       = 1'b1;
                            div_dividend    = 32'(rec_t_reg);
                            div_divisor     = {8'd0, tdiv_eff};
                            kind_next       = DK_SCL_T;
                        end
                        DK_SCL_T:
                        begin
                            rec_t_next   = div_quot[15:0];
                            div_start    = 1'b1;
                            div_dividend = 32'(rec_v_reg);
                            div_divisor  = {8'd0, vdiv_eff};
                            kind_next    = DK_SCL_V;
                        end
                        DK_SCL_V:
                        begin
                            rec_v_next = div_quot[15:0];
                            state_next = S_STORE_WR;
                        end
                        DK_MRG_T:
                        begin
                            rec_t_next   = div_quot[15:0];
                            div_start    = 1'b1;
                            div_dividend = $signed(m_av_reg);
                            div_divisor  = 16'(m_cnt_reg);
                            kind_next    = DK_MRG_V;
                        end
                        DK_MRG_V:
                        begin
                            rec_v_next = div_quot[15:0];
                            state_next = S_M_WR;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            // Write the new record at the head
            S_STORE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = head_reg;
                ram_wdata = '{source: rec_src_reg, temp: rec_t_reg,
                              vcc: rec_v_reg, minutes: rec_min_reg};
                if (tail_reg == head_reg)
                begin
                    tail_next = idx_next(tail_reg);
                end
                head_next = idx_next(head_reg);
                sum16     = msh_reg + {8'd0, rec_min_reg};
                msh_next  = sum16;
                if (sum16 > HOUR_TRIGGER)
                begin
                    m_three_next = 1'b0;
                    state_next   = S_M_START;
                end
                else
                begin
                    state_next = S_ADD3;
                end
            end

            S_ADD3:
            begin
                sum16    = ms3_reg + {8'd0, rec_min_reg};
                ms3_next = sum16;
                if (sum16 > THREE_HOUR_TRIGGER)
                begin
                    m_three_next = 1'b1;
                    state_next   = S_M_START;
                end
                else
                begin
                    state_next = S_POST;
                end
            end

            S_POST:
            begin
                state_next = (op_reg == OP_SAMPLE) ? S_DIFF_RD : S_FINISH;
            end

            // Merge: start the walk at the merge index
            S_M_START:
            begin
                idx_tmp     = m_three_reg ? h3idx_reg : hidx_reg;
                m_src_next  = idx_tmp;
                m_dst_next  = idx_tmp;
                m_mins_next = '0;
                m_at_next   = '0;
                m_av_next   = '0;
                m_cnt_next  = '0;
                ram_re      = 1'b1;
                ram_raddr   = idx_tmp;
                state_next  = S_M_ACC;
            end

            // Merge: sum records until the span is covered or the head is reached
            S_M_ACC:
            begin
                sum16       = m_mins_reg + {8'd0, ram_rdata.minutes};
                m_mins_next = sum16;
                m_at_next   = m_at_reg + {{16{ram_rdata.temp[15]}}, ram_rdata.temp};
                m_av_next   = m_av_reg + {{16{ram_rdata.vcc[15]}}, ram_rdata.vcc};
                m_cnt_next  = CNT_W'(m_cnt_reg + 1'b1);
                if (m_cnt_reg == '0)
                begin
                    m_source_next = ram_rdata.source;
                end
                idx_tmp    = idx_next(m_src_reg);
                m_src_next = idx_tmp;
                limit      = m_three_reg ? THREE_HOUR_SPAN : HOUR_SPAN;
                if ((idx_tmp != head_reg) && (sum16 < limit))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_tmp;
                end
                else
                begin
                    state_next = S_M_DIV;
                end
            end

            S_M_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = $signed(m_at_reg);
                div_divisor  = 16'(m_cnt_reg);
                kind_next    = DK_MRG_T;
                state_next   = S_DIV_WAIT;
            end

            // Merge: write the averaged record, then compact the rest, if any
            S_M_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = m_dst_reg;
                ram_wdata = '{source: m_source_reg, temp: rec_t_reg,
                              vcc: rec_v_reg, minutes: m_mins_reg[7:0]};
                idx_tmp    = idx_next(m_dst_reg);
                m_dst_next = idx_tmp;
                if (m_three_reg)
                begin
                    h3idx_next = idx_tmp;
                end
                else
                begin
                    hidx_next = idx_tmp;
                end
                m_mins_next = '0;
                if (m_src_reg != head_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = m_src_reg;
                    state_next = S_M_CP;
                end
                else
                begin
                    state_next = S_M_DONE;
                end
            end

            // Compaction: move one record down per cycle
            S_M_CP:
            begin
                ram_we      = 1'b1;
                ram_waddr   = m_dst_reg;
                ram_wdata   = ram_rdata;
                m_mins_next = m_mins_reg + {8'd0, ram_rdata.minutes};
                if (m_three_reg && (m_src_reg == hidx_reg))
                begin
                    hidx_next = m_dst_reg;
                end
                idx_tmp    = idx_next(m_src_reg);
                m_src_next = idx_tmp;
                m_dst_next = idx_next(m_dst_reg);
                if (idx_tmp != head_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_tmp;
                end
                else
                begin
                    state_next = S_M_DONE;
                end
            end

            S_M_DONE:
            begin
                head_next = m_dst_reg;
                if (m_three_reg)
                begin
                    ms3_next   = m_mins_reg;
                    state_next = S_POST;
                end
                else
                begin
                    msh_next   = m_mins_reg;
                    state_next = S_ADD3;
                end
            end

            // Difference against the newest record
            S_DIFF_RD:
            begin
                idx_tmp = idx_prev(head_reg);
                if (idx_tmp != tail_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_tmp;
                    state_next = S_DIFF_MUL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end

            S_DIFF_MUL:
            begin
                prod_next  = prod_full[15:0];
                state_next = S_DIFF_SUB;
            end

            S_DIFF_SUB:
            begin
                res_diff_next = tin_reg - prod_reg;
                state_next    = S_FINISH;
            end

            // Iterator reached a record
            S_IT_DATA:
            begin
                sum16        = it_min_reg + {8'd0, ram_rdata.minutes};
                it_min_next  = sum16;
                res_ev_next  = 1'b1;
                res_src_next = ram_rdata.source;
                res_t_next   = ram_rdata.temp;
                res_v_next   = ram_rdata.vcc;
                res_min_next = ram_rdata.minutes;
                res_mb_next  = sum16;
                state_next   = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= DK_AVG_T;
            acc_reg       <= 8'd5;
            tdiv_reg      <= 8'd1;
            vdiv_reg      <= 8'd1;
            head_reg      <= '0;
            tail_reg      <= LAST_IDX;
            tsum_reg      <= '0;
            vsum_reg      <= '0;
            scount_reg    <= '0;
            last_min_reg  <= '0;
            msh_reg       <= '0;
            ms3_reg       <= '0;
            hidx_reg      <= '0;
            h3idx_reg     <= '0;
            it_idx_reg    <= '0;
            it_min_reg    <= '0;
            m_three_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            tsum_reg      <= tsum_next;
            vsum_reg      <= vsum_next;
            scount_reg    <= scount_next;
            last_min_reg  <= last_min_next;
            msh_reg       <= msh_next;
            ms3_reg       <= ms3_next;
            hidx_reg      <= hidx_next;
            h3idx_reg     <= h3idx_next;
            it_idx_reg    <= it_idx_next;
            it_min_reg    <= it_min_next;
            m_three_reg   <= m_three_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACC:  acc_reg  <= cfg_data;
                    CFG_TDIV: tdiv_reg <= cfg_data;
                    CFG_VDIV: vdiv_reg <= cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= op;
            now_reg  <= minute_now;
            tin_reg  <= temp;
            vin_reg  <= vcc;
            rsrc_reg <= record_source;
            rmin_reg <= record_minutes;
        end
        rec_src_reg    <= rec_src_next;
        rec_t_reg      <= rec_t_next;
        rec_v_reg      <= rec_v_next;
        rec_min_reg    <= rec_min_next;
        m_src_reg      <= m_src_next;
        m_dst_reg      <= m_dst_next;
        m_mins_reg     <= m_mins_next;
        m_at_reg       <= m_at_next;
        m_av_reg       <= m_av_next;
        m_cnt_reg      <= m_cnt_next;
        m_source_reg   <= m_source_next;
        prod_reg       <= prod_next;
        res_stored_reg <= res_stored_next;
        res_diff_reg   <= res_diff_next;
        res_ev_reg     <= res_ev_next;
        res_src_reg    <= res_src_next;
        res_t_reg      <= res_t_next;
        res_v_reg      <= res_v_next;
        res_min_reg    <= res_min_next;
        res_mb_reg     <= res_mb_next;
        if (load_out)
        begin
            o_stored_reg <= res_stored_reg;
            o_diff_reg   <= res_diff_reg;
            o_ev_reg     <= res_ev_reg;
            o_src_reg    <= res_src_reg;
            o_t_reg      <= res_t_reg;
            o_v_reg      <= res_v_reg;
            o_min_reg    <= res_min_reg;
            o_mb_reg     <= res_mb_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign stored         = o_stored_reg;
    assign diff           = o_diff_reg;
    assign entry_valid    = o_ev_reg;
    assign entry_source   = o_src_reg;
    assign entry_temp     = o_t_reg;
    assign entry_vcc      = o_v_reg;
    assign entry_minutes  = o_min_reg;
    assign minutes_before = o_mb_reg;

    // Checks
    `SHC_ASSERT(a_idle_head_stable, clk, rst_n, (state_reg == S_IDLE) |=> $stable(head_reg))
    `SHC_ASSERT(a_div_done_in_wait, clk, rst_n, div_done |-> (state_reg == S_DIV_WAIT))
    `SHC_ASSERT(a_out_from_finish, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_FINISH))
    `SHC_ASSERT_NEVER(a_no_write_idle, clk, rst_n, ram_we && (state_reg == S_IDLE))

endmodule
